/* rtl/cic_pkg.sv */
// Shared constants, register codes and the corner table for the cloud-in-cell block.
// No dependencies; every other file in rtl/ uses it.
`default_nettype none

package cic_pkg;

   localparam int MAX_GRID_DEF         = 1024;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 8;

   localparam int POS_W      = 32;
   localparam int LEN_W      = 32;
   localparam int GRID_REG_W = 11;
   localparam int CELL_W     = 10;
   localparam int FLAT_W     = 30;
   localparam int WEIGHT_W   = 17;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [GRID_REG_W-1:0] GRID_N_RESET  = 11'd64;
   localparam logic [LEN_W-1:0]      BOX_LEN_RESET = 32'd65536;

   typedef enum logic [2:0] {
      REG_GRID_N_X  = 3'd0,
      REG_GRID_N_Y  = 3'd1,
      REG_GRID_N_Z  = 3'd2,
      REG_BOX_LEN_X = 3'd3,
      REG_BOX_LEN_Y = 3'd4,
      REG_BOX_LEN_Z = 3'd5
   } reg_index_type;

   // Corner order base, x, y, z, xy, xz, yz, xyz; bit 0 shifts x, bit 1 y, bit 2 z.
   localparam logic [2:0] CORNER_MASK [NUM_CORNERS] = '{
      3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b101, 3'b110, 3'b111
   };

   localparam logic [2:0] LAST_CORNER = 3'd7;

endpackage

`default_nettype wire

/* rtl/cic_channel_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on cic_pkg for the field widths.
`default_nettype none

interface cic_req_if;
   logic                       valid;
   logic                       ready;
   logic [cic_pkg::POS_W-1:0]  pos_x;
   logic [cic_pkg::POS_W-1:0]  pos_y;
   logic [cic_pkg::POS_W-1:0]  pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface cic_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cic_pkg::CELL_W-1:0]    cell_x;
   logic [cic_pkg::CELL_W-1:0]    cell_y;
   logic [cic_pkg::CELL_W-1:0]    cell_z;
   logic [cic_pkg::FLAT_W-1:0]    flat_index;
   logic [cic_pkg::WEIGHT_W-1:0]  weight;
   logic                          last;

   modport source (output valid, output cell_x, output cell_y, output cell_z,
                   output flat_index, output weight, output last, input ready);
   modport sink   (input valid, input cell_x, input cell_y, input cell_z,
                   input flat_index, input weight, input last, output ready);
endinterface

`default_nettype wire

/* rtl/cic_axis_solve.sv */
// Per-axis cell search: position times grid count, pipelined long division by the
// box length, then offset, neighbor and axis weights. Depends on cic_pkg.
`default_nettype none

module cic_axis_solve #(
   parameter int MAX_GRID         = cic_pkg::MAX_GRID_DEF,
   parameter int WEIGHT_FRAC_BITS = cic_pkg::WEIGHT_FRAC_BITS_DEF,
   localparam int GB = $clog2(MAX_GRID),
   localparam int NB = $clog2(MAX_GRID + 1),
   localparam int W1 = WEIGHT_FRAC_BITS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [cic_pkg::POS_W-1:0]  in_pos    [cic_pkg::NUM_AXES],
   input  logic [NB-1:0]              grid_n    [cic_pkg::NUM_AXES],
   input  logic [cic_pkg::LEN_W-1:0]  box_len   [cic_pkg::NUM_AXES],
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [GB-1:0]              out_cell  [cic_pkg::NUM_AXES],
   output logic [GB-1:0]              out_nbr   [cic_pkg::NUM_AXES],
   output logic [W1-1:0]              out_wnear [cic_pkg::NUM_AXES],
   output logic [W1-1:0]              out_wfar  [cic_pkg::NUM_AXES]
);

   localparam int F  = WEIGHT_FRAC_BITS;
   localparam int K  = GB + F;
   localparam int NS = K + 2;
   localparam int NA = cic_pkg::NUM_AXES;
   localparam int LW = cic_pkg::LEN_W;
   localparam int PW = cic_pkg::POS_W + NB;
   localparam logic [W1-1:0] ONE  = {1'b1, {F{1'b0}}};
   localparam logic [W1-1:0] HALF = {2'b01, {(F-1){1'b0}}};

   logic          en;
   logic [NS-1:0] v_ff, v_in;

   assign en        = !v_ff[NS-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[NS-1];
   assign v_in      = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // front stage: scale position by grid count, flag positions at or past the box length
   logic [PW-1:0] a_prod_ff  [NA];
   logic [PW-1:0] a_prod_in  [NA];
   logic [NA-1:0] a_clamp_ff, a_clamp_in;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         a_prod_in[i]  = PW'(in_pos[i]) * PW'(grid_n[i]);
         a_clamp_in[i] = in_pos[i] >= box_len[i];
      end
   end

   // divider stages: one quotient bit each; quotient is cell and fraction joined
   logic [LW-1:0] d_rem_ff   [K][NA];
   logic [LW-1:0] d_rem_in   [K][NA];
   logic [K-1:0]  d_quo_ff   [K][NA];
   logic [K-1:0]  d_quo_in   [K][NA];
   logic [NA-1:0] d_clamp_ff [K];
   logic [NA-1:0] d_clamp_in [K];

   genvar s, x;
   generate
      for (s = 0; s < K; s++) begin : g_div
         for (x = 0; x < NA; x++) begin : g_ax
            logic [LW-1:0] src_rem;
            logic [K-1:0]  src_quo;
            logic [LW:0]   cat;
            logic [LW:0]   diff;
            logic          ge;

            if (s == 0) begin : g_first
               logic [PW-1:0] prod_hi;
               always_comb begin
                  prod_hi = a_prod_ff[x] >> GB;
                  src_rem = prod_hi[LW-1:0];
                  src_quo = {a_prod_ff[x][GB-1:0], {F{1'b0}}};
               end
            end else begin : g_next
               assign src_rem = d_rem_ff[s-1][x];
               assign src_quo = d_quo_ff[s-1][x];
            end

            assign cat  = {src_rem, src_quo[K-1]};
            assign diff = cat - {1'b0, box_len[x]};
            assign ge   = cat >= {1'b0, box_len[x]};
            assign d_rem_in[s][x] = ge ? diff[LW-1:0] : cat[LW-1:0];
            assign d_quo_in[s][x] = {src_quo[K-2:0], ge};
         end

         if (s == 0) begin : g_clamp_first
            assign d_clamp_in[s] = a_clamp_ff;
         end else begin : g_clamp_next
            assign d_clamp_in[s] = d_clamp_ff[s-1];
         end
      end
   endgenerate

   // post stage: offset from cell center, neighbor with wrap, axis weights
   logic [GB-1:0] p_cell_ff  [NA];
   logic [GB-1:0] p_cell_in  [NA];
   logic [GB-1:0] p_nbr_ff   [NA];
   logic [GB-1:0] p_nbr_in   [NA];
   logic [W1-1:0] p_wnear_ff [NA];
   logic [W1-1:0] p_wnear_in [NA];
   logic [W1-1:0] p_wfar_ff  [NA];
   logic [W1-1:0] p_wfar_in  [NA];

   always_comb begin
      logic [K-1:0]  q;
      logic [GB-1:0] home;
      logic [NB-1:0] cell_ext;
      logic [W1-1:0] frac;
      logic [W1-1:0] offs;
      logic          up;
      for (int i = 0; i < NA; i++) begin
         q = d_quo_ff[K-1][i];
         if (d_clamp_ff[K-1][i]) begin
            // on the upper edge of the last cell
            home = GB'(grid_n[i] - 1'b1);
            frac = ONE;
         end else begin
            home = q[K-1:F];
            frac = {1'b0, q[F-1:0]};
         end
         up       = frac >= HALF;
         offs     = up ? frac - HALF : HALF - frac;
         cell_ext = NB'(home);
         if (up) begin
            p_nbr_in[i] = (cell_ext + 1'b1 == grid_n[i]) ? '0 : home + 1'b1;
         end else begin
            p_nbr_in[i] = (home == '0) ? GB'(grid_n[i] - 1'b1) : home - 1'b1;
         end
         p_cell_in[i]  = home;
         p_wnear_in[i] = ONE - offs;
         p_wfar_in[i]  = offs;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_prod_ff  <= a_prod_in;
         a_clamp_ff <= a_clamp_in;
         d_rem_ff   <= d_rem_in;
         d_quo_ff   <= d_quo_in;
         d_clamp_ff <= d_clamp_in;
         p_cell_ff  <= p_cell_in;
         p_nbr_ff   <= p_nbr_in;
         p_wnear_ff <= p_wnear_in;
         p_wfar_ff  <= p_wfar_in;
      end
   end

   assign out_cell  = p_cell_ff;
   assign out_nbr   = p_nbr_ff;
   assign out_wnear = p_wnear_ff;
   assign out_wfar  = p_wfar_ff;

endmodule

`default_nettype wire

/* rtl/cic_corner_gen.sv */
// Corner sequencer and corner math: walks the eight corners of one particle and
// forms indices, flat index and trilinear weight in two stages. Depends on cic_pkg.
`default_nettype none

module cic_corner_gen #(
   parameter int MAX_GRID         = cic_pkg::MAX_GRID_DEF,
   parameter int WEIGHT_FRAC_BITS = cic_pkg::WEIGHT_FRAC_BITS_DEF,
   localparam int GB = $clog2(MAX_GRID),
   localparam int NB = $clog2(MAX_GRID + 1),
   localparam int W1 = WEIGHT_FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [GB-1:0]                 in_cell   [cic_pkg::NUM_AXES],
   input  logic [GB-1:0]                 in_nbr    [cic_pkg::NUM_AXES],
   input  logic [W1-1:0]                 in_wnear  [cic_pkg::NUM_AXES],
   input  logic [W1-1:0]                 in_wfar   [cic_pkg::NUM_AXES],
   input  logic [NB-1:0]                 grid_n_y,
   input  logic [NB-1:0]                 grid_n_z,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [cic_pkg::CELL_W-1:0]    out_cell_x,
   output logic [cic_pkg::CELL_W-1:0]    out_cell_y,
   output logic [cic_pkg::CELL_W-1:0]    out_cell_z,
   output logic [cic_pkg::FLAT_W-1:0]    out_flat_index,
   output logic [cic_pkg::WEIGHT_W-1:0]  out_weight,
   output logic                          out_last
);

   localparam int F   = WEIGHT_FRAC_BITS;
   localparam int NA  = cic_pkg::NUM_AXES;
   localparam int W2  = 2 * W1;
   localparam int TW  = 2 * NB;
   localparam int FW  = 3 * NB;
   localparam int CXW = GB + cic_pkg::CELL_W;
   localparam int FXW = FW + cic_pkg::FLAT_W;
   localparam int WXW = W1 + cic_pkg::WEIGHT_W;
   localparam logic [W2-1:0] RND = W2'(1) << (F - 1);

   logic en, issue, take;

   // sequencer: holds one particle, issues one corner per advance
   logic          busy_ff, busy_in;
   logic [2:0]    k_ff, k_in;
   logic [GB-1:0] s_cell_ff  [NA];
   logic [GB-1:0] s_nbr_ff   [NA];
   logic [W1-1:0] s_wnear_ff [NA];
   logic [W1-1:0] s_wfar_ff  [NA];

   assign en       = !out_valid || out_ready;
   assign issue    = busy_ff && en;
   assign in_ready = !busy_ff || (issue && k_ff == cic_pkg::LAST_CORNER);
   assign take     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (take) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (issue) begin
         k_in = k_ff + 1'b1;
         if (k_ff == cic_pkg::LAST_CORNER) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_cell_ff  <= in_cell;
         s_nbr_ff   <= in_nbr;
         s_wnear_ff <= in_wnear;
         s_wfar_ff  <= in_wfar;
      end
   end

   // first math stage: pick corner, x*y weight, partial flat index
   logic          m_v_ff, m_v_in;
   logic [GB-1:0] m_cx_ff, m_cy_ff, m_cz_ff, m_cx_in, m_cy_in, m_cz_in;
   logic [W1-1:0] m_wxy_ff, m_wz_ff, m_wxy_in, m_wz_in;
   logic [TW-1:0] m_t_ff, m_t_in;
   logic          m_last_ff, m_last_in;

   always_comb begin
      logic [2:0]    mask;
      logic [GB-1:0] c [NA];
      logic [W1-1:0] w [NA];
      logic [W2-1:0] prod_xy;
      mask = cic_pkg::CORNER_MASK[k_ff];
      for (int i = 0; i < NA; i++) begin
         c[i] = mask[i] ? s_nbr_ff[i]  : s_cell_ff[i];
         w[i] = mask[i] ? s_wfar_ff[i] : s_wnear_ff[i];
      end
      prod_xy   = W2'(w[0]) * W2'(w[1]) + RND;
      m_wxy_in  = prod_xy[F +: W1];
      m_t_in    = TW'(c[1]) + TW'(grid_n_y) * TW'(c[0]);
      m_cx_in   = c[0];
      m_cy_in   = c[1];
      m_cz_in   = c[2];
      m_wz_in   = w[2];
      m_last_in = (k_ff == cic_pkg::LAST_CORNER);
      m_v_in    = issue;
   end

   // second math stage into the output register
   logic                          o_v_ff, o_v_in;
   logic [cic_pkg::CELL_W-1:0]    o_cx_ff, o_cy_ff, o_cz_ff, o_cx_in, o_cy_in, o_cz_in;
   logic [cic_pkg::FLAT_W-1:0]    o_flat_ff, o_flat_in;
   logic [cic_pkg::WEIGHT_W-1:0]  o_weight_ff, o_weight_in;
   logic                          o_last_ff, o_last_in;

   always_comb begin
      logic [W2-1:0]  prod_w;
      logic [W1-1:0]  wfin;
      logic [FW-1:0]  flat_full;
      logic [CXW-1:0] cx_ext, cy_ext, cz_ext;
      logic [FXW-1:0] flat_ext;
      logic [WXW-1:0] w_ext;
      prod_w      = W2'(m_wxy_ff) * W2'(m_wz_ff) + RND;
      wfin        = prod_w[F +: W1];
      flat_full   = FW'(m_cz_ff) + FW'(grid_n_z) * FW'(m_t_ff);
      cx_ext      = CXW'(m_cx_ff);
      cy_ext      = CXW'(m_cy_ff);
      cz_ext      = CXW'(m_cz_ff);
      flat_ext    = FXW'(flat_full);
      w_ext       = WXW'(wfin);
      o_cx_in     = cx_ext[cic_pkg::CELL_W-1:0];
      o_cy_in     = cy_ext[cic_pkg::CELL_W-1:0];
      o_cz_in     = cz_ext[cic_pkg::CELL_W-1:0];
      o_flat_in   = flat_ext[cic_pkg::FLAT_W-1:0];
      o_weight_in = w_ext[cic_pkg::WEIGHT_W-1:0];
      o_last_in   = m_last_ff;
      o_v_in      = m_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= m_v_in;
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_cx_ff     <= m_cx_in;
         m_cy_ff     <= m_cy_in;
         m_cz_ff     <= m_cz_in;
         m_wxy_ff    <= m_wxy_in;
         m_wz_ff     <= m_wz_in;
         m_t_ff      <= m_t_in;
         m_last_ff   <= m_last_in;
         o_cx_ff     <= o_cx_in;
         o_cy_ff     <= o_cy_in;
         o_cz_ff     <= o_cz_in;
         o_flat_ff   <= o_flat_in;
         o_weight_ff <= o_weight_in;
         o_last_ff   <= o_last_in;
      end
   end

   assign out_valid      = o_v_ff;
   assign out_cell_x     = o_cx_ff;
   assign out_cell_y     = o_cy_ff;
   assign out_cell_z     = o_cz_ff;
   assign out_flat_index = o_flat_ff;
   assign out_weight     = o_weight_ff;
   assign out_last       = o_last_ff;

endmodule

`default_nettype wire

/* rtl/cloud_in_cell_assign.sv */
// Cloud-in-cell assignment top: CSR block, axis solver pipeline, corner generator.
// Flow: the eight corners of a request share the one response port, so the corner
// generator takes a request only when idle or as the last corner issues; the
// divider pipeline takes a request every cycle while its output is not stalled.
// Reset: synchronous, active high; clears valid bits and loads register defaults.
// Depends on cic_pkg, cic_channel_if, cic_axis_solve and cic_corner_gen.
`default_nettype none

module cloud_in_cell_assign #(
   parameter int MAX_GRID         = cic_pkg::MAX_GRID_DEF,
   parameter int WEIGHT_FRAC_BITS = cic_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   cic_req_if.sink                         req,
   cic_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cic_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cic_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cic_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int GB = $clog2(MAX_GRID);
   localparam int NB = $clog2(MAX_GRID + 1);
   localparam int W1 = WEIGHT_FRAC_BITS + 1;
   localparam int NA = cic_pkg::NUM_AXES;
   localparam int GR = cic_pkg::GRID_REG_W;
   localparam int LW = cic_pkg::LEN_W;
   // compare width for saturating the grid count against MAX_GRID
   localparam int CW = ((NB > GR) ? NB : GR) + 1;

   // ------------------------------------------------------------------
   // Configuration registers. Writes complete in the access phase; pready
   // is tied high so no access waits past its access phase.
   // ------------------------------------------------------------------
   logic [GR-1:0] grid_n_ff  [NA];
   logic [GR-1:0] grid_n_in  [NA];
   logic [LW-1:0] box_len_ff [NA];
   logic [LW-1:0] box_len_in [NA];
   logic          csr_wr;
   logic [2:0]    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[cic_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      grid_n_in  = grid_n_ff;
      box_len_in = box_len_ff;
      if (csr_wr) begin
         case (cic_pkg::reg_index_type'(csr_idx))
            cic_pkg::REG_GRID_N_X:  grid_n_in[0]  = csr_pwdata[GR-1:0];
            cic_pkg::REG_GRID_N_Y:  grid_n_in[1]  = csr_pwdata[GR-1:0];
            cic_pkg::REG_GRID_N_Z:  grid_n_in[2]  = csr_pwdata[GR-1:0];
            cic_pkg::REG_BOX_LEN_X: box_len_in[0] = csr_pwdata[LW-1:0];
            cic_pkg::REG_BOX_LEN_Y: box_len_in[1] = csr_pwdata[LW-1:0];
            cic_pkg::REG_BOX_LEN_Z: box_len_in[2] = csr_pwdata[LW-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            grid_n_ff[i]  <= cic_pkg::GRID_N_RESET;
            box_len_ff[i] <= cic_pkg::BOX_LEN_RESET;
         end
      end else begin
         grid_n_ff  <= grid_n_in;
         box_len_ff <= box_len_in;
      end
   end

   // read back the raw register values
   always_comb begin
      case (cic_pkg::reg_index_type'(csr_idx))
         cic_pkg::REG_GRID_N_X:  csr_prdata = cic_pkg::CSR_DATA_W'(grid_n_ff[0]);
         cic_pkg::REG_GRID_N_Y:  csr_prdata = cic_pkg::CSR_DATA_W'(grid_n_ff[1]);
         cic_pkg::REG_GRID_N_Z:  csr_prdata = cic_pkg::CSR_DATA_W'(grid_n_ff[2]);
         cic_pkg::REG_BOX_LEN_X: csr_prdata = cic_pkg::CSR_DATA_W'(box_len_ff[0]);
         cic_pkg::REG_BOX_LEN_Y: csr_prdata = cic_pkg::CSR_DATA_W'(box_len_ff[1]);
         cic_pkg::REG_BOX_LEN_Z: csr_prdata = cic_pkg::CSR_DATA_W'(box_len_ff[2]);
         default:                csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Effective configuration: a zero grid count acts as one cell, a count
   // above MAX_GRID saturates, and a zero box length acts as one LSB.
   // The user must change registers only while idle; the block does not
   // enforce it. Every pipeline stage reads these directly, no copies.
   // ------------------------------------------------------------------
   logic [NB-1:0] grid_eff [NA];
   logic [LW-1:0] len_eff  [NA];

   always_comb begin
      logic [CW-1:0] n_ext;
      for (int i = 0; i < NA; i++) begin
         n_ext = CW'(grid_n_ff[i]);
         if (n_ext == '0) begin
            grid_eff[i] = NB'(1);
         end else if (n_ext > CW'(MAX_GRID)) begin
            grid_eff[i] = NB'(MAX_GRID);
         end else begin
            grid_eff[i] = NB'(n_ext);
         end
         len_eff[i] = (box_len_ff[i] == '0) ? LW'(1) : box_len_ff[i];
      end
   end

   // ------------------------------------------------------------------
   // Axis solver: multiply, GB+F divider stages, post stage.
   // ------------------------------------------------------------------
   logic [cic_pkg::POS_W-1:0] req_pos [NA];
   logic                      ax_valid, ax_ready;
   logic [GB-1:0]             ax_cell  [NA];
   logic [GB-1:0]             ax_nbr   [NA];
   logic [W1-1:0]             ax_wnear [NA];
   logic [W1-1:0]             ax_wfar  [NA];

   assign req_pos[0] = req.pos_x;
   assign req_pos[1] = req.pos_y;
   assign req_pos[2] = req.pos_z;

   cic_axis_solve #(
      .MAX_GRID         (MAX_GRID),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_axis_solve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_pos    (req_pos),
      .grid_n    (grid_eff),
      .box_len   (len_eff),
      .out_valid (ax_valid),
      .out_ready (ax_ready),
      .out_cell  (ax_cell),
      .out_nbr   (ax_nbr),
      .out_wnear (ax_wnear),
      .out_wfar  (ax_wfar)
   );

   // ------------------------------------------------------------------
   // Corner generator: takes the next request while its last corner
   // issues, so corners stream without a gap between particles.
   // ------------------------------------------------------------------
   cic_corner_gen #(
      .MAX_GRID         (MAX_GRID),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_corner_gen (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (ax_valid),
      .in_ready       (ax_ready),
      .in_cell        (ax_cell),
      .in_nbr         (ax_nbr),
      .in_wnear       (ax_wnear),
      .in_wfar        (ax_wfar),
      .grid_n_y       (grid_eff[1]),
      .grid_n_z       (grid_eff[2]),
      .out_valid      (rsp.valid),
      .out_ready      (rsp.ready),
      .out_cell_x     (rsp.cell_x),
      .out_cell_y     (rsp.cell_y),
      .out_cell_z     (rsp.cell_z),
      .out_flat_index (rsp.flat_index),
      .out_weight     (rsp.weight),
      .out_last       (rsp.last)
   );

endmodule

`default_nettype wire

/* rtl/cic_checker.sv */
// Port-level checks for cloud_in_cell_assign and the bind that attaches them.
// Depends on cic_pkg; bound to the top level.
`default_nettype none

module cic_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [cic_pkg::CELL_W-1:0]    rsp_cell_x,
   input wire logic [cic_pkg::CELL_W-1:0]    rsp_cell_y,
   input wire logic [cic_pkg::CELL_W-1:0]    rsp_cell_z,
   input wire logic [cic_pkg::FLAT_W-1:0]    rsp_flat_index,
   input wire logic [cic_pkg::WEIGHT_W-1:0]  rsp_weight,
   input wire logic                          rsp_last
);

   logic        req_fire, rsp_fire, done_fire;
   logic [2:0]  corner_ff, corner_in;
   logic [15:0] pend_ff, pend_in;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign done_fire = rsp_fire && rsp_last;
   assign corner_in = rsp_fire ? corner_ff + 1'b1 : corner_ff;
   assign pend_in   = pend_ff + 16'(req_fire) - 16'(done_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         pend_ff   <= '0;
      end else begin
         corner_ff <= corner_in;
         pend_ff   <= pend_in;
      end
   end

   // hold a stalled response steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_x) && $stable(rsp_cell_y)
         && $stable(rsp_cell_z) && $stable(rsp_flat_index) && $stable(rsp_weight)
         && $stable(rsp_last))
      else $error("response changed while stalled");

   // last marks every eighth response and no other
   a_last_every_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_last == (corner_ff == cic_pkg::LAST_CORNER)))
      else $error("last flag out of step with corner count");

   // no response without a request still open
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("response with no open request");

   // response channel comes out of reset empty
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind cloud_in_cell_assign cic_checker u_cic_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_cell_x     (rsp.cell_x),
   .rsp_cell_y     (rsp.cell_y),
   .rsp_cell_z     (rsp.cell_z),
   .rsp_flat_index (rsp.flat_index),
   .rsp_weight     (rsp.weight),
   .rsp_last       (rsp.last)
);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for cloud_in_cell_assign: particle requests in, eight corner cells out.
// Uses cic_pkg, the cic_req_if / cic_rsp_if interfaces and the cloud_in_cell_assign top from rtl/.
`timescale 1ns / 1ps

module testbench;

   // Slack after the last corner before a register write, and the no-progress limit.
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam int                   FRAC_BITS   = cic_pkg::WEIGHT_FRAC_BITS_DEF;
   localparam logic [63:0]          UNIT_WEIGHT = 64'd1 << FRAC_BITS;
   localparam logic [63:0]          HALF_CELL   = UNIT_WEIGHT >> 1;
   localparam logic [63:0]          GRID_LIMIT  = 64'(cic_pkg::MAX_GRID_DEF);
   localparam logic [10:0]          GRID_AT_RESET = 11'd64;
   localparam logic [31:0]          BOX_AT_RESET  = 32'h0001_0000;
   // First register index past the map; writes there must change nothing.
   localparam logic [2:0]           UNMAPPED_REG = 3'd6;

   // Corner order base, x, y, z, xy, xz, yz, xyz; bit 0 moves x, bit 1 y, bit 2 z.
   localparam logic [2:0] CLOUD_CORNER_SHIFT [cic_pkg::NUM_CORNERS] = '{
      3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b101, 3'b110, 3'b111
   };

   typedef struct {
      logic [63:0] home;
      logic [63:0] nbr;
      logic [63:0] w_near;
      logic [63:0] w_far;
   } axis_split_type;

   typedef struct {
      logic [cic_pkg::CELL_W-1:0]   cell_x;
      logic [cic_pkg::CELL_W-1:0]   cell_y;
      logic [cic_pkg::CELL_W-1:0]   cell_z;
      logic [cic_pkg::FLAT_W-1:0]   flat_index;
      logic [cic_pkg::WEIGHT_W-1:0] weight;
      logic                         last;
   } cloud_corner_type;

   logic clock;
   logic reset;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [cic_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cic_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cic_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   cic_req_if req_if ();
   cic_rsp_if rsp_if ();

   cloud_in_cell_assign dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the geometry registers, updated on every completed write.
   logic [10:0] grid_setting [cic_pkg::NUM_AXES];
   logic [31:0] box_setting  [cic_pkg::NUM_AXES];

   // Corners still owed by the block, oldest first.
   cloud_corner_type pending_corners [$];
   int               mismatches = 0;

   // Sender pacing state: burst length left, and whether gaps are allowed at all.
   int burst_left   = 0;
   bit gaps_enabled = 1'b1;

   // Receiver stall pattern state.
   int stall_style  = 0;
   int pattern_left = 0;

   int idle_cycles = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Zero counts act as one cell; counts past the grid limit saturate.
   function automatic logic [63:0] effective_grid(logic [10:0] n_reg);
      if (n_reg == 0) return 64'd1;
      if (64'(n_reg) > GRID_LIMIT) return GRID_LIMIT;
      return 64'(n_reg);
   endfunction

   // A zero box length acts as one LSB.
   function automatic logic [63:0] effective_box(logic [31:0] len_reg);
      return (len_reg == 0) ? 64'd1 : 64'(len_reg);
   endfunction

   // Locate a position on one axis: home cell, neighbor on the side of the offset,
   // and the two axis weights.
   function automatic axis_split_type split_axis(logic [31:0] pos, logic [10:0] n_reg,
                                                 logic [31:0] len_reg);
      axis_split_type s;
      logic [63:0] n, len, pos64, prod, frac, offset;
      logic        upward;
      n     = effective_grid(n_reg);
      len   = effective_box(len_reg);
      pos64 = 64'(pos);
      if (pos64 >= len) begin
         // at or past the box edge: pin to the top edge of the last cell
         s.home = n - 1;
         frac   = UNIT_WEIGHT;
      end else begin
         prod   = pos64 * n;
         s.home = prod / len;
         frac   = ((prod % len) << FRAC_BITS) / len;
      end
      // a particle exactly on the cell center counts as offset upward
      upward = (frac >= HALF_CELL);
      offset = upward ? frac - HALF_CELL : HALF_CELL - frac;
      if (upward) s.nbr = (s.home + 1 == n) ? 64'd0 : s.home + 1;
      else        s.nbr = (s.home == 0) ? n - 1 : s.home - 1;
      s.w_near = UNIT_WEIGHT - offset;
      s.w_far  = offset;
      return s;
   endfunction

   // Fixed-point product with round half up.
   function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + (UNIT_WEIGHT >> 1)) >> FRAC_BITS;
   endfunction

   // Queue the eight corners that one accepted particle must produce.
   function automatic void predict_corners(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      axis_split_type   ax [cic_pkg::NUM_AXES];
      logic [31:0]      pos [cic_pkg::NUM_AXES];
      logic [63:0]      corner_idx [cic_pkg::NUM_AXES];
      logic [63:0]      w [cic_pkg::NUM_AXES];
      logic [63:0]      ny, nz, flat, wt;
      cloud_corner_type c;
      int               a, k;
      pos[0] = px;
      pos[1] = py;
      pos[2] = pz;
      for (a = 0; a < cic_pkg::NUM_AXES; a++)
         ax[a] = split_axis(pos[a], grid_setting[a], box_setting[a]);
      ny = effective_grid(grid_setting[1]);
      nz = effective_grid(grid_setting[2]);
      for (k = 0; k < cic_pkg::NUM_CORNERS; k++) begin
         for (a = 0; a < cic_pkg::NUM_AXES; a++) begin
            corner_idx[a] = CLOUD_CORNER_SHIFT[k][a] ? ax[a].nbr   : ax[a].home;
            w[a]          = CLOUD_CORNER_SHIFT[k][a] ? ax[a].w_far : ax[a].w_near;
         end
         flat = corner_idx[2] + nz * (corner_idx[1] + ny * corner_idx[0]);
         wt   = round_mul(round_mul(w[0], w[1]), w[2]);
         c.cell_x     = corner_idx[0][cic_pkg::CELL_W-1:0];
         c.cell_y     = corner_idx[1][cic_pkg::CELL_W-1:0];
         c.cell_z     = corner_idx[2][cic_pkg::CELL_W-1:0];
         c.flat_index = flat[cic_pkg::FLAT_W-1:0];
         c.weight     = wt[cic_pkg::WEIGHT_W-1:0];
         c.last       = (k == cic_pkg::NUM_CORNERS - 1);
         pending_corners = {pending_corners, c};
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checking: every accepted corner against the oldest owed one
   // ---------------------------------------------------------------------------------------

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : corner_checker
      cloud_corner_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_corners.size() == 0) begin
            $display("%0t: corner with none expected, expected nothing, got flat_index %0d",
                     $time, rsp_if.flat_index);
            mismatches++;
         end else begin
            want = pending_corners.pop_front();
            check_field("cell_x",     32'(want.cell_x),     32'(rsp_if.cell_x));
            check_field("cell_y",     32'(want.cell_y),     32'(rsp_if.cell_y));
            check_field("cell_z",     32'(want.cell_z),     32'(rsp_if.cell_z));
            check_field("flat_index", 32'(want.flat_index), 32'(rsp_if.flat_index));
            check_field("weight",     32'(want.weight),     32'(rsp_if.weight));
            check_field("last",       32'(want.last),       32'(rsp_if.last));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: ready follows a stall style that changes every so often
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (pattern_left == 0) begin
         stall_style  <= $urandom_range(0, 3);
         pattern_left <= $urandom_range(16, 160);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      case (stall_style)
         0: rsp_if.ready <= 1'b1;                              // full rate, no stalls
         1: rsp_if.ready <= ($urandom_range(0, 3) != 0);       // light random stalls
         2: rsp_if.ready <= ($urandom_range(0, 3) == 0);       // heavy backpressure
         default: rsp_if.ready <= (pattern_left % 7 < 4);      // fixed duty cycle
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: any request, corner or register access counts as progress
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------------

   // After each request: count down the burst; at its end maybe drop valid for a gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = gaps_enabled ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Present one particle, hold it until accepted, then queue its corners.
   task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      req_if.valid <= 1'b1;
      req_if.pos_x <= px;
      req_if.pos_y <= py;
      req_if.pos_z <= pz;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_corners(px, py, pz);
      pace_sender();
   endtask

   // Drop valid, wait until every owed corner has come, then let the pipeline settle.
   task automatic wait_for_quiet();
      req_if.valid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------------------------

   // Setup then access phase; the write lands at the access edge.
   task automatic write_register(logic [2:0] index, logic [31:0] value);
      logic [2:0] slot;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         cic_pkg::REG_GRID_N_X, cic_pkg::REG_GRID_N_Y, cic_pkg::REG_GRID_N_Z:
            grid_setting[index[1:0]] = value[10:0];
         cic_pkg::REG_BOX_LEN_X, cic_pkg::REG_BOX_LEN_Y, cic_pkg::REG_BOX_LEN_Z: begin
            slot = index - 3'(cic_pkg::REG_BOX_LEN_X);
            box_setting[slot[1:0]] = value;
         end
         default: ;   // past the register map: nothing changes
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [10:0] nx, logic [10:0] ny, logic [10:0] nz,
                               logic [31:0] lx, logic [31:0] ly, logic [31:0] lz);
      write_register(cic_pkg::REG_BOX_LEN_X - 3'd3, {21'd0, nx});
      write_register(cic_pkg::REG_GRID_N_Y,  {21'd0, ny});
      write_register(cic_pkg::REG_GRID_N_Z,  {21'd0, nz});
      write_register(cic_pkg::REG_BOX_LEN_X, lx);
      write_register(cic_pkg::REG_BOX_LEN_Y, ly);
      write_register(cic_pkg::REG_BOX_LEN_Z, lz);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random positions: mostly inside the box, some near cell centers, some at or past
   // the box edge, some anywhere in the 32-bit range
   // ---------------------------------------------------------------------------------------

   function automatic logic [31:0] random_position(int axis);
      logic [63:0] n, len, centre;
      n   = effective_grid(grid_setting[axis]);
      len = effective_box(box_setting[axis]);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            if (len >= 64'hFFFF_FFF0) return $urandom;
            centre = len + 64'($urandom_range(0, 15));
            return centre[31:0];
         end
         3, 4: begin
            // near a cell center, where the offset changes sign
            centre = 64'($urandom_range(0, 32'(n - 1)));
            centre = ((2 * centre + 1) * len) / (2 * n) + 64'($urandom_range(0, 2));
            if (centre > 0) centre = centre - 1;
            if (centre > 64'hFFFF_FFFF) centre = 64'hFFFF_FFFF;
            return centre[31:0];
         end
         default: return $urandom_range(0, 32'(len - 1));
      endcase
   endfunction

   function automatic logic [10:0] random_grid();
      case ($urandom_range(0, 7))
         0: return 11'd0;
         1: return 11'($urandom_range(1025, 2047));
         2: return 11'd1;
         3: return 11'd1024;
         default: return 11'($urandom_range(1, 1024));
      endcase
   endfunction

   function automatic logic [31:0] random_box();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return $urandom_range(1, 16);
         2: return 32'hFFFF_FFFF;
         3, 4: return $urandom;
         default: return $urandom_range(32'h0001_0000, 32'h0100_0000);
      endcase
   endfunction

   task automatic send_random_particles(int count);
      repeat (count) send_particle(random_position(0), random_position(1), random_position(2));
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset geometry: 64 cells over one unit on every axis, so a cell is 1024 LSBs wide.
   task automatic test_default_geometry();
      send_particle(32'd0, 32'd0, 32'd0);                     // lower edge: wrap down to 63
      send_particle(32'd512, 32'd512, 32'd512);               // exactly on center: step up
      send_particle(32'd511, 32'd513, 32'd1536);              // x, y just off center; z on center
      send_particle(32'd65535, 32'd65535, 32'd65535);         // last cell: wrap up to 0
      send_particle(32'd65536, 32'd65536, 32'd65536);         // on the box length: clamp
      send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_particle(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
      send_particle(32'd1, 32'd65534, 32'd700);
      send_random_particles(30);
   endtask

   // One cell, the grid limit and a saturated count; tiny, full and zero box lengths.
   task automatic test_grid_extremes();
      wait_for_quiet();
      set_geometry(11'd1, 11'd1024, 11'd2047, 32'd1, 32'hFFFF_FFFF, 32'd0);
      send_particle(32'd0, 32'd0, 32'd0);
      send_particle(32'd1, 32'hFFFF_FFFE, 32'd1);
      send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_particle(32'd0, 32'h7FFF_FFFF, 32'd0);
      send_particle(32'd5, 32'h0020_0000, 32'd2);
      // a write past the register map must leave the geometry alone
      wait_for_quiet();
      write_register(UNMAPPED_REG, 32'h0000_0003);
      send_particle(32'd0, 32'h8000_0000, 32'd0);
      send_particle(32'd0, 32'h0040_0000, 32'd0);
      send_particle(32'd0, 32'hFFBF_FFFF, 32'd0);
      send_random_particles(40);
   endtask

   // Zero grid count on x, two cells on y, short boxes on x and y.
   task automatic test_zero_grid_short_box();
      wait_for_quiet();
      set_geometry(11'd0, 11'd2, 11'd1023, 32'd0, 32'd3, 32'h0003_0000);
      send_particle(32'd0, 32'd0, 32'd0);
      send_particle(32'd0, 32'd1, 32'h0002_FFFF);
      send_particle(32'd1, 32'd2, 32'h0001_8000);
      send_particle(32'd7, 32'd3, 32'h0000_00C0);
      send_random_particles(40);
   endtask

   // Largest grid on every axis with full-range boxes: flat index near its top.
   // Run this one with no sender gaps.
   task automatic test_full_grid_no_gaps();
      wait_for_quiet();
      set_geometry(11'd1024, 11'd1024, 11'd1024,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      gaps_enabled = 1'b0;
      send_particle(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
      send_particle(32'd0, 32'd0, 32'd0);
      send_random_particles(50);
      gaps_enabled = 1'b1;
   endtask

   // Several random geometries, gaps switched on or off per round.
   task automatic test_random_geometry();
      repeat (4) begin
         wait_for_quiet();
         set_geometry(random_grid(), random_grid(), random_grid(),
                      random_box(), random_box(), random_box());
         gaps_enabled = ($urandom_range(0, 3) != 0);
         send_random_particles(22);
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      int a;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.pos_z = '0;
      rsp_if.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      for (a = 0; a < cic_pkg::NUM_AXES; a++) begin
         grid_setting[a] = GRID_AT_RESET;
         box_setting[a]  = BOX_AT_RESET;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_geometry();
      test_grid_extremes();
      test_zero_grid_short_box();
      test_full_grid_no_gaps();
      test_random_geometry();

      wait_for_quiet();
      if (mismatches == 0 && pending_corners.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/cic_pkg.sv
rtl/cic_channel_if.sv
rtl/cic_axis_solve.sv
rtl/cic_corner_gen.sv
rtl/cloud_in_cell_assign.sv
rtl/cic_checker.sv
sim/testbench.sv
